// ----- rtl/bpos_pkg.sv -----
// shared types and constants for the box pair overlap scan block
package bpos_pkg;

   localparam int DEF_NUM_COMPONENTS = 32;

   localparam int IDX_FIELD_W = 5;
   localparam int COORD_W     = 24;
   localparam int VOL_W       = 48;
   localparam int AXIS_W      = 4;
   localparam int RATIO_W     = 17;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // axis-code products that select a radial case
   localparam logic [7:0] PROD_XY = 8'd3;
   localparam logic [7:0] PROD_XZ = 8'd8;
   localparam logic [7:0] PROD_YZ = 8'd30;

   localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

   typedef struct packed {
      logic                       opcode;
      logic [IDX_FIELD_W-1:0]     comp_index;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic [COORD_W-1:0]         size_x;
      logic [COORD_W-1:0]         size_y;
      logic [COORD_W-1:0]         size_z;
      logic [VOL_W-1:0]           comp_volume;
      logic                       is_cylinder;
      logic [AXIS_W-1:0]          axis_code;
   } req_type;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] partner_index;
      logic [RATIO_W-1:0]     overlap_ratio;
      logic                   last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [COORD_W-1:0]        size_x;
      logic [COORD_W-1:0]        size_y;
      logic [COORD_W-1:0]        size_z;
      logic [VOL_W-1:0]          volume;
      logic                      cylinder;
      logic [AXIS_W-1:0]         axis;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      RAD_NONE = 2'd0,
      RAD_XY   = 2'd1,
      RAD_XZ   = 2'd2,
      RAD_YZ   = 2'd3
   } rad_type;

endpackage

// ----- rtl/bpos_ram.sv -----
// generic single-port-write, registered-read ram
module bpos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/box_pair_overlap_scan.sv -----
// top level of the box pair overlap scan: component table and scan engine
//
// usage
//   request channel (req_valid / req_stall / req_data): a load request writes
//   one component into the table; an evaluate request scans every other table
//   entry in ascending index order and gives one response per partner.
//   response channel (rsp_valid / rsp_stall / rsp_data): partner index, the
//   overlap ratio in unsigned q1.16 and a last flag on the final response.
// evaluate sequencing
//   a load leaves the engine idle. an evaluate takes one partner at a time: a pair
//   that cannot overlap goes from the check straight to emit, an overlapping box
//   pair runs the product and, unless the ratio saturates, the 17-step divide,
//   and the radial case runs the 25-step square root before the check.
// reset
//   synchronous reset returns the engine to idle and drops rsp_valid; the
//   table is not cleared, entries must be loaded before they are scanned.
// stall
//   a finished response sits in the output register; while it is stalled the
//   engine holds its next result and waits. a new request is taken only when
//   the engine is idle, even while the last response still waits.
module box_pair_overlap_scan
   import bpos_pkg::*;
#(
   parameter int NUM_COMPONENTS = DEF_NUM_COMPONENTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(NUM_COMPONENTS);
   localparam int SCAN_W = IDX_W + 1;
   localparam int CMP_W  = (SCAN_W > IDX_FIELD_W) ? SCAN_W : IDX_FIELD_W;
   localparam int PEN_W  = 27;   // doubled penetration, signed
   localparam int SQ_W   = 50;   // square-root operand and partial root
   localparam int SUM_W  = VOL_W + 1;
   localparam int PROD_W = 75;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_READ  = 12'b0000_0000_0010,
      S_CALC  = 12'b0000_0000_0100,
      S_SQ    = 12'b0000_0000_1000,
      S_SQRT  = 12'b0000_0001_0000,
      S_CHECK = 12'b0000_0010_0000,
      S_MUL1  = 12'b0000_0100_0000,
      S_MUL2  = 12'b0000_1000_0000,
      S_MUL3  = 12'b0001_0000_0000,
      S_SUM   = 12'b0010_0000_0000,
      S_DIV   = 12'b0100_0000_0000,
      S_EMIT  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // candidate and scan position
   req_type           cand_ff, cand_in;
   logic [CMP_W-1:0]  scan_ff, scan_in;

   // per-partner datapath registers
   logic signed [PEN_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [COORD_W-1:0]      ada_ff, ada_in, adb_ff, adb_in;
   logic [COORD_W:0]        dsum_ff, dsum_in;
   rad_type                 rad_ff, rad_in;
   logic [SUM_W-1:0]        vsum_ff, vsum_in;
   logic [SQ_W-1:0]         num_ff, num_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0]              step_ff, step_in;
   logic [SQ_W-1:0]         a_ff, a_in, plo_ff, plo_in, phi_ff, phi_in;
   logic [SQ_W-1:0]         rem_ff, rem_in;
   logic [RATIO_W-1:0]      nb_ff, nb_in, q_ff, q_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // table
   entry_type        wr_entry, rd_entry;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CMP_W-1:0] req_idx_ext, cand_idx_ext, nxt1, nxt;
   logic             scan_done;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_idx_ext = CMP_W'(req_data.comp_index);
   assign cand_idx_ext = CMP_W'(cand_ff.comp_index);

   assign wr_en   = req_valid && !req_stall && (req_data.opcode == OP_LOAD)
                    && (req_idx_ext < CMP_W'(NUM_COMPONENTS));
   assign wr_addr = req_idx_ext[IDX_W-1:0];
   assign rd_en   = (state_ff == S_READ);

   always_comb begin
      wr_entry.pos_x    = req_data.pos_x;
      wr_entry.pos_y    = req_data.pos_y;
      wr_entry.pos_z    = req_data.pos_z;
      wr_entry.size_x   = req_data.size_x;
      wr_entry.size_y   = req_data.size_y;
      wr_entry.size_z   = req_data.size_z;
      wr_entry.volume   = req_data.comp_volume;
      wr_entry.cylinder = req_data.is_cylinder;
      wr_entry.axis     = req_data.axis_code;
   end

   bpos_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_COMPONENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   // next partner index, skipping the candidate itself
   assign nxt1      = scan_ff + CMP_W'(1);
   assign nxt       = (nxt1 == cand_idx_ext) ? (nxt1 + CMP_W'(1)) : nxt1;
   assign scan_done = (nxt >= CMP_W'(NUM_COMPONENTS));

   // absolute center distance along one axis
   function automatic logic [COORD_W-1:0] abs_diff(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? -d : d;
      return m[COORD_W-1:0];
   endfunction

   // doubled box penetration
   function automatic logic signed [PEN_W-1:0] box_pen(
      input logic [COORD_W-1:0] s1,
      input logic [COORD_W-1:0] s2,
      input logic [COORD_W-1:0] ad
   );
      return $signed(PEN_W'(s1) + PEN_W'(s2) - {2'b00, ad, 1'b0});
   endfunction

   // combinational helpers
   logic [COORD_W-1:0]      c_adx, c_ady, c_adz;
   logic signed [PEN_W-1:0] c_dx, c_dy, c_dz, rad_pen;
   logic [7:0]              c_prod;
   logic                    both_cyl;
   logic [SQ_W-1:0]         sq_trial;
   logic [PROD_W-1:0]       p_full;
   logic [SQ_W-1:0]         div_trial;
   logic                    step_last_sqrt, step_last_div;

   always_comb begin
      c_adx    = abs_diff(cand_ff.pos_x, rd_entry.pos_x);
      c_ady    = abs_diff(cand_ff.pos_y, rd_entry.pos_y);
      c_adz    = abs_diff(cand_ff.pos_z, rd_entry.pos_z);
      c_dx     = box_pen(cand_ff.size_x, rd_entry.size_x, c_adx);
      c_dy     = box_pen(cand_ff.size_y, rd_entry.size_y, c_ady);
      c_dz     = box_pen(cand_ff.size_z, rd_entry.size_z, c_adz);
      c_prod   = 8'(cand_ff.axis_code * rd_entry.axis);
      both_cyl = cand_ff.is_cylinder && rd_entry.cylinder;
      sq_trial = root_ff + bit_ff;
      rad_pen  = $signed(PEN_W'(dsum_ff) - {1'b0, root_ff[COORD_W:0], 1'b0});
      p_full   = PROD_W'(plo_ff) + {phi_ff, 25'd0};
      div_trial = {rem_ff[SQ_W-2:0], nb_ff[RATIO_W-1]};
      step_last_sqrt = (step_ff == 5'd24);
      step_last_div  = (step_ff == 5'(RATIO_W - 1));
   end

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      scan_in      = scan_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      ada_in       = ada_ff;
      adb_in       = adb_ff;
      dsum_in      = dsum_ff;
      rad_in       = rad_ff;
      vsum_in      = vsum_ff;
      num_in       = num_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      a_in         = a_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      rem_in       = rem_ff;
      nb_in        = nb_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_data.opcode == OP_EVAL)) begin
               cand_in  = req_data;
               scan_in  = (req_idx_ext == '0) ? CMP_W'(1) : '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            dx_in   = c_dx;
            dy_in   = c_dy;
            dz_in   = c_dz;
            vsum_in = SUM_W'(cand_ff.comp_volume) + SUM_W'(rd_entry.volume);
            rad_in  = RAD_NONE;
            ada_in  = c_adx;
            adb_in  = c_ady;
            dsum_in = (COORD_W+1)'(cand_ff.size_x) + (COORD_W+1)'(rd_entry.size_x);
            if (both_cyl) begin
               priority if (c_prod == PROD_XY && c_dz > 0) begin
                  rad_in = RAD_XY;
               end else if (c_prod == PROD_XZ && c_dy > 0) begin
                  rad_in = RAD_XZ;
                  adb_in = c_adz;
               end else if (c_prod == PROD_YZ && c_dx > 0) begin
                  rad_in  = RAD_YZ;
                  ada_in  = c_ady;
                  adb_in  = c_adz;
                  dsum_in = (COORD_W+1)'(cand_ff.size_y) + (COORD_W+1)'(rd_entry.size_y);
               end else begin
                  rad_in = RAD_NONE;
               end
            end
            state_in = (both_cyl && ((c_prod == PROD_XY && c_dz > 0)
                        || (c_prod == PROD_XZ && c_dy > 0)
                        || (c_prod == PROD_YZ && c_dx > 0))) ? S_SQ : S_CHECK;
         end
         S_SQ: begin
            // squared distance in the radial plane
            num_in   = SQ_W'(ada_ff * ada_ff) + SQ_W'(adb_ff * adb_ff);
            root_in  = '0;
            bit_in   = SQ_W'(1) << 48;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // one root bit per cycle
            if (num_ff >= sq_trial) begin
               num_in  = num_ff - sq_trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_last_sqrt) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // root_ff holds the finished root when a radial case ran
            unique case (rad_ff)
               RAD_XY: begin
                  dx_in = rad_pen;
                  dy_in = rad_pen;
               end
               RAD_XZ: begin
                  dx_in = rad_pen;
                  dz_in = rad_pen;
               end
               RAD_YZ: begin
                  dy_in = rad_pen;
                  dz_in = rad_pen;
               end
               default: begin
               end
            endcase
            rad_in   = RAD_NONE;
            state_in = S_CHECK;
            if (rad_ff == RAD_NONE) begin
               if (dx_ff > 0 && dy_ff > 0 && dz_ff > 0 && vsum_ff != '0) begin
                  state_in = S_MUL1;
               end else begin
                  q_in     = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_MUL1: begin
            a_in     = SQ_W'(dx_ff[24:0] * dy_ff[24:0]);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            plo_in   = SQ_W'(a_ff[24:0] * dz_ff[24:0]);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            phi_in   = SQ_W'(a_ff[49:25] * dz_ff[24:0]);
            state_in = S_SUM;
         end
         S_SUM: begin
            if (p_full >= PROD_W'({vsum_ff, 2'b00})) begin
               q_in     = RATIO_ONE;
               state_in = S_EMIT;
            end else begin
               rem_in   = p_full[SQ_W+2:3];
               nb_in    = {p_full[2:0], 14'd0};
               q_in     = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (div_trial >= SQ_W'(vsum_ff)) begin
               rem_in = div_trial - SQ_W'(vsum_ff);
               q_in   = {q_ff[RATIO_W-2:0], 1'b1};
            end else begin
               rem_in = div_trial;
               q_in   = {q_ff[RATIO_W-2:0], 1'b0};
            end
            nb_in   = {nb_ff[RATIO_W-2:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_last_div) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.partner_index = scan_ff[IDX_FIELD_W-1:0];
               rsp_data_in.overlap_ratio = q_ff;
               rsp_data_in.last_result   = scan_done;
               scan_in                   = nxt;
               state_in                  = scan_done ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rad_ff       <= RAD_NONE;
         step_ff      <= '0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rad_ff       <= rad_in;
         step_ff      <= step_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      ada_ff      <= ada_in;
      adb_ff      <= adb_in;
      dsum_ff     <= dsum_in;
      vsum_ff     <= vsum_in;
      num_ff      <= num_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      a_ff        <= a_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      rem_ff      <= rem_in;
      nb_ff       <= nb_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/box_pair_overlap_scan_tb.sv -----
// self-checking testbench for the box pair overlap scan block
`timescale 1ns / 1ps

module box_pair_overlap_scan_tb;
   import bpos_pkg::*;

   localparam int TABLE_DEPTH = DEF_NUM_COMPONENTS;
   localparam int QUIET_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;

   // table mirror plus the queue of overlap results still owed by the block
   class overlap_scoreboard;
      entry_type table_copy[TABLE_DEPTH];
      rsp_type   owed_q[$];
      int        errors;

      function new();
         errors = 0;
      endfunction

      function automatic longint axis_pen(longint s1, longint s2, longint c1, longint c2);
         longint d;
         d = (c1 > c2) ? c1 - c2 : c2 - c1;
         return s1 + s2 - 2 * d;
      endfunction

      function automatic longint floor_root(longint unsigned n);
         longint unsigned r, t;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
         end
         return longint'(r);
      endfunction

      function automatic longint radial_pen(longint d1, longint d2, longint a1, longint a2,
                                            longint b1, longint b2);
         longint unsigned da, db;
         da = (a1 > a2) ? a1 - a2 : a2 - a1;
         db = (b1 > b2) ? b1 - b2 : b2 - b1;
         return d1 + d2 - 2 * floor_root(da * da + db * db);
      endfunction

      function automatic logic [RATIO_W-1:0] overlap_of(longint dx, longint dy, longint dz,
                                                       longint unsigned vsum);
         logic [127:0] num, q;
         if (vsum == 0) return '0;
         num = 128'(dx) * 128'(dy) * 128'(dz);
         num = num << 14;
         q = num / 128'(vsum);
         if (q > 128'(RATIO_ONE)) return RATIO_ONE;
         return q[RATIO_W-1:0];
      endfunction

      function void note_request(req_type r);
         entry_type e;
         rsp_type res;
         longint px, py, pz, qx, qy, qz, dx, dy, dz;
         int unsigned prod;
         int count;
         if (r.opcode == OP_LOAD) begin
            table_copy[r.comp_index] = '{r.pos_x, r.pos_y, r.pos_z, r.size_x, r.size_y,
                                         r.size_z, r.comp_volume, r.is_cylinder, r.axis_code};
            return;
         end
         px = r.pos_x;
         py = r.pos_y;
         pz = r.pos_z;
         count = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == r.comp_index) continue;
            e = table_copy[i];
            qx = e.pos_x;
            qy = e.pos_y;
            qz = e.pos_z;
            dx = axis_pen(r.size_x, e.size_x, px, qx);
            dy = axis_pen(r.size_y, e.size_y, py, qy);
            dz = axis_pen(r.size_z, e.size_z, pz, qz);
            if (r.is_cylinder && e.cylinder) begin
               prod = r.axis_code * e.axis;
               if (prod == PROD_XY && dz > 0) begin
                  dx = radial_pen(r.size_x, e.size_x, px, qx, py, qy);
                  dy = dx;
               end else if (prod == PROD_XZ && dy > 0) begin
                  dx = radial_pen(r.size_x, e.size_x, px, qx, pz, qz);
                  dz = dx;
               end else if (prod == PROD_YZ && dx > 0) begin
                  dy = radial_pen(r.size_y, e.size_y, py, qy, pz, qz);
                  dz = dy;
               end
            end
            res.partner_index = i[IDX_FIELD_W-1:0];
            res.overlap_ratio = '0;
            res.last_result = 1'b0;
            if (dx > 0 && dy > 0 && dz > 0)
               res.overlap_ratio = overlap_of(dx, dy, dz,
                  longint'(r.comp_volume) + longint'(e.volume));
            owed_q.push_back(res);
            count++;
         end
         if (count > 0) owed_q[owed_q.size() - 1].last_result = 1'b1;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected response partner %0d ratio %0d last %0b", $time,
                     got.partner_index, got.overlap_ratio, got.last_result);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.partner_index !== want.partner_index) begin
            $display("%0t: partner_index expected %0d actual %0d", $time,
                     want.partner_index, got.partner_index);
            errors++;
         end
         if (got.overlap_ratio !== want.overlap_ratio) begin
            $display("%0t: overlap_ratio (partner %0d) expected %0d actual %0d", $time,
                     want.partner_index, want.overlap_ratio, got.overlap_ratio);
            errors++;
         end
         if (got.last_result !== want.last_result) begin
            $display("%0t: last_result (partner %0d) expected %0b actual %0b", $time,
                     want.partner_index, want.last_result, got.last_result);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   overlap_scoreboard sb = new();

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   bit hold_taken;
   int hold_left;
   int quiet_cycles;

   box_pair_overlap_scan dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // response side: random stalls, plus one long hold-off to back the block up
   initial begin
      rsp_stall = 1'b0;
      hold_taken = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // response monitor and watchdog on both channels going quiet
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("box_pair_overlap_scan verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // drive one request and note it once the block takes it
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   function automatic req_type make_entry(logic op, int idx, int px, int py, int pz,
                                          int sx, int sy, int sz, int cyl, int ax);
      req_type r;
      r.opcode = op;
      r.comp_index = idx[IDX_FIELD_W-1:0];
      r.pos_x = px[COORD_W-1:0];
      r.pos_y = py[COORD_W-1:0];
      r.pos_z = pz[COORD_W-1:0];
      r.size_x = sx[COORD_W-1:0];
      r.size_y = sy[COORD_W-1:0];
      r.size_z = sz[COORD_W-1:0];
      r.comp_volume = VOL_W'(longint'(sx) * longint'(sy) * longint'(sz));
      r.is_cylinder = cyl[0];
      r.axis_code = ax[AXIS_W-1:0];
      return r;
   endfunction

   // mostly clustered components so overlaps are common, some raw noise for bit coverage
   function automatic req_type random_request(logic op);
      req_type r;
      logic [223:0] noise;
      int spread;
      if ($urandom_range(99) < 12) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         r = noise[$bits(req_type)-1:0];
         r.opcode = op;
         return r;
      end
      spread = ($urandom_range(3) == 0) ? 16'hffff : 12'hfff;
      r = make_entry(op, $urandom_range(31),
                     $urandom_range(2 * spread) - spread,
                     $urandom_range(2 * spread) - spread,
                     $urandom_range(2 * spread) - spread,
                     $urandom_range(14'h3fff), $urandom_range(14'h3fff),
                     $urandom_range(14'h3fff),
                     int'($urandom_range(99) < 45), $urandom_range(15));
      if ($urandom_range(9) == 0) r.comp_volume = VOL_W'({$urandom, $urandom});
      if ($urandom_range(19) == 0) r.comp_volume = '0;
      if ($urandom_range(9) == 0) r.size_x = COORD_W'($urandom);
      return r;
   endfunction

   initial begin
      req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: identical boxes, cylinders for each radial axis pairing,
      // zero volume, coordinate and size extremes, a far-away box
      send_request(make_entry(OP_LOAD, 0, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 0));
      send_request(make_entry(OP_LOAD, 1, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 0));
      send_request(make_entry(OP_LOAD, 2, 'h100, 'h80, 0, 'h800, 'h800, 'h1000, 1, 1));
      send_request(make_entry(OP_LOAD, 3, 'h200, -'h100, 'h40, 'h900, 'h800, 'h800, 1, 3));
      send_request(make_entry(OP_LOAD, 4, -'h80, 'h10, 'h180, 'h700, 'h900, 'h600, 1, 4));
      send_request(make_entry(OP_LOAD, 5, 'h20, 'h140, -'h1c0, 'h600, 'h700, 'h800, 1, 6));
      r = make_entry(OP_LOAD, 6, 'h10, 'h10, 'h10, 'h400, 'h400, 'h400, 0, 0);
      r.comp_volume = '0;
      send_request(r);
      r = make_entry(OP_LOAD, 7, 'h7fffff, 'h7fffff, 'h7fffff, 0, 0, 0, 1, 15);
      r.size_x = '1;
      r.size_y = '1;
      r.size_z = '1;
      r.comp_volume = '1;
      send_request(r);
      r = make_entry(OP_LOAD, 8, -'h800000, -'h800000, -'h800000, 0, 0, 0, 0, 0);
      r.size_x = '1;
      r.size_y = '1;
      r.size_z = '1;
      r.comp_volume = '1;
      send_request(r);
      send_request(make_entry(OP_LOAD, 9, 'h300000, -'h300000, 'h300000, 'h10, 'h10, 'h10,
                              1, 2));
      for (int i = 10; i < TABLE_DEPTH; i++) begin
         r = random_request(OP_LOAD);
         r.comp_index = i[IDX_FIELD_W-1:0];
         send_request(r);
      end

      send_request(make_entry(OP_EVAL, 0, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 0));
      send_request(make_entry(OP_EVAL, 2, 0, 0, 0, 'h800, 'h800, 'h1000, 1, 1));
      send_request(make_entry(OP_EVAL, 31, 'h40, 0, 'h20, 'h800, 'h800, 'h800, 1, 2));
      send_request(make_entry(OP_EVAL, 30, 0, 'h20, 0, 'h800, 'h900, 'h800, 1, 5));
      r = make_entry(OP_EVAL, 0, 'h10, 'h10, 'h10, 'h400, 'h400, 'h400, 0, 3);
      r.comp_volume = '0;
      send_request(r);
      r = make_entry(OP_EVAL, 7, -'h800000, 'h7fffff, 0, 0, 0, 0, 1, 15);
      r.size_x = '1;
      r.size_y = '1;
      r.size_z = '1;
      r.comp_volume = '1;
      send_request(r);

      // random part: four idle mixes, about 470 requests in all
      for (int n = 0; n < 432; n++) begin
         case (n / 108)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         // long receiver hold-off while requests keep coming
         if (n == 60) hold_request = 1'b1;
         send_request(random_request(($urandom_range(99) < 30) ? OP_EVAL : OP_LOAD));
      end
      req_valid <= 1'b0;

      while (sb.owed_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("box_pair_overlap_scan verification clean");
      end else begin
         $display("box_pair_overlap_scan verification failed");
      end
      $finish;
   end

endmodule
